[sv/fpsc_pkg.sv]
// shared constants, types and helpers for the five-point stencil checksum block
package fpsc_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 8;
    localparam int OUT_BITS    = 26;
    localparam int SUM_OUT_BITS = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int WIDTH_BITS  = 11;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    // wide enough for five products and for the saturation limits
    localparam int SUM_BITS    = (PROD_BITS + 3 > OUT_BITS) ? PROD_BITS + 3 : OUT_BITS + 1;

    localparam logic [WIDTH_BITS-1:0] MIN_ROW = WIDTH_BITS'(3);

    localparam logic signed [SUM_BITS-1:0] SAT_MAX = SUM_BITS'((2 ** (OUT_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] SAT_MIN = SUM_BITS'(-(2 ** (OUT_BITS - 1)));

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_COEF_CENTER = 3'd0,
        REG_COEF_UP     = 3'd1,
        REG_COEF_DOWN   = 3'd2,
        REG_COEF_LEFT   = 3'd3,
        REG_COEF_RIGHT  = 3'd4,
        REG_ROW_WIDTH   = 3'd5
    } cfg_reg_t;

    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;

    // row width as used: below three acts as three, above the store depth as the depth
    function automatic logic [WIDTH_BITS-1:0] eff_width(input logic [WIDTH_BITS-1:0] w);
        logic [WIDTH_BITS-1:0] r;
        r = w;
        if (w < MIN_ROW)
        begin
            r = MIN_ROW;
        end
        else if (int'(w) > MAX_WIDTH)
        begin
            r = WIDTH_BITS'(MAX_WIDTH);
        end
        return r;
    endfunction

    // column clamped below the row width, as a store address
    function automatic logic [COL_BITS-1:0] clamp_col(input logic [COL_BITS-1:0] c,
                                                      input logic [WIDTH_BITS-1:0] w);
        logic [COL_BITS-1:0] r;
        r = c;
        if ({1'b0, c} >= w)
        begin
            r = COL_BITS'(w - WIDTH_BITS'(1));
        end
        return r;
    endfunction

endpackage

[sv/five_point_stencil_checksum.sv]
// top level of the five-point weighted stencil with running frame checksum
//
// Samples come in raster order, one transfer per cycle at full rate, with the
// row width taken from the row_width register. Two line stores (one per
// previous row, each a simple dual-port array with registered read data) and a
// four-sample window supply the neighbours of each interior point; a result
// transfer is produced for interior points only, so the first two rows and the
// first two columns of each row give none. The line stores are read
// ahead at the column the next sample will land in, which lets a new sample be
// taken every cycle. Five coefficient products are registered in the first
// stage; the second stage adds them, saturates to 26 bits and updates the
// running checksum in the output register. While a result waits at the
// output, input transfers go on until the next result reaches the product
// stage; only then is the input stalled. The running checksum restarts after
// any sample marked frame_end. The line stores are never cleared: after reset or
// a frame end the first rows fill them before any point reads them.
module five_point_stencil_checksum (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [fpsc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [fpsc_pkg::WIDTH_BITS-1:0]      cfg_wdata,
    // sample input
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [fpsc_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                 frame_end,
    // result output
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [fpsc_pkg::OUT_BITS-1:0] stencil_value,
    output logic [fpsc_pkg::SUM_OUT_BITS-1:0]    running_checksum,
    output logic                                 last
);
    import fpsc_pkg::*;

    // configuration registers
    coef_t                 c_center_reg, c_up_reg, c_down_reg, c_left_reg, c_right_reg;
    logic [WIDTH_BITS-1:0] row_width_reg;
    logic [WIDTH_BITS-1:0] row_width_next;

    // line stores and their registered read data
    sample_t one_back_mem [MAX_WIDTH];
    sample_t two_back_mem [MAX_WIDTH];
    sample_t right_reg;     // line_one_back at the current column
    sample_t up_here_reg;   // line_two_back at the current column

    // window: down is current row c-1, left/center row r-1, up row r-2
    sample_t w_down_reg, w_left_reg, w_center_reg, w_up_reg;

    // raster position
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [1:0]          rows_reg, rows_next;
    logic                clr_pend_reg;   // a frame ended since the last result

    // product stage
    logic  a_valid_reg;
    prod_t p_center_reg, p_up_reg, p_down_reg, p_left_reg, p_right_reg;
    logic  a_last_reg, a_restart_reg;

    // output stage
    logic                         out_valid_reg;
    logic signed [OUT_BITS-1:0]   value_reg;
    logic [SUM_OUT_BITS-1:0]      checksum_reg;
    logic                         last_reg;

    logic [WIDTH_BITS-1:0] width_eff;
    logic [COL_BITS-1:0]   col_use;
    logic [COL_BITS-1:0]   rd_addr;
    logic                  in_xfer;
    logic                  b_load;
    logic                  produce;
    logic signed [SUM_BITS-1:0]   sum;
    logic signed [OUT_BITS-1:0]   sat_value;
    logic [SUM_OUT_BITS-1:0]      sum_base;

    assign width_eff = eff_width(row_width_reg);
    assign col_use   = clamp_col(col_reg, width_eff);

    // handshake: output register loads when empty or being taken
    assign b_load   = !out_valid_reg || !out_stall;
    assign in_stall = a_valid_reg && !b_load;
    assign in_xfer  = in_valid && !in_stall;
    assign produce  = (rows_reg >= 2'd2) && (col_use >= COL_BITS'(2));

    // row width seen by the next sample, for the look-ahead read address
    always_comb
    begin
        row_width_next = row_width_reg;
        if (cfg_we && (cfg_reg_t'(cfg_index) == REG_ROW_WIDTH))
        begin
            row_width_next = cfg_wdata;
        end
    end

    // next raster position
    always_comb
    begin
        col_next  = col_reg;
        rows_next = rows_reg;
        if (in_xfer)
        begin
            if (({1'b0, col_reg} + WIDTH_BITS'(1)) >= width_eff)
            begin
                col_next = '0;
                if (rows_reg < 2'd2)
                begin
                    rows_next = rows_reg + 2'd1;
                end
            end
            else
            begin
                col_next = col_reg + COL_BITS'(1);
            end
            if (frame_end)
            begin
                col_next  = '0;
                rows_next = '0;
            end
        end
    end

    // read the stores at the column the next sample will use
    assign rd_addr = clamp_col(col_next, eff_width(row_width_next));

    // configuration writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_center_reg  <= COEF_BITS'(1);
            c_up_reg      <= COEF_BITS'(2);
            c_down_reg    <= COEF_BITS'(3);
            c_left_reg    <= COEF_BITS'(4);
            c_right_reg   <= COEF_BITS'(5);
            row_width_reg <= WIDTH_BITS'(1000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COEF_CENTER: c_center_reg  <= cfg_wdata[COEF_BITS-1:0];
                REG_COEF_UP:     c_up_reg      <= cfg_wdata[COEF_BITS-1:0];
                REG_COEF_DOWN:   c_down_reg    <= cfg_wdata[COEF_BITS-1:0];
                REG_COEF_LEFT:   c_left_reg    <= cfg_wdata[COEF_BITS-1:0];
                REG_COEF_RIGHT:  c_right_reg   <= cfg_wdata[COEF_BITS-1:0];
                REG_ROW_WIDTH:   row_width_reg <= row_width_next;
                default:         ;
            endcase
        end
    end

    // line stores: write on a sample transfer, read ahead every cycle
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            one_back_mem[col_use] <= sample;
            two_back_mem[col_use] <= right_reg;
        end
        right_reg   <= one_back_mem[rd_addr];
        up_here_reg <= two_back_mem[rd_addr];
    end

    // window and raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_down_reg   <= '0;
            w_left_reg   <= '0;
            w_center_reg <= '0;
            w_up_reg     <= '0;
            col_reg      <= '0;
            rows_reg     <= '0;
            clr_pend_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            rows_reg <= rows_next;
            if (in_xfer)
            begin
                w_down_reg   <= sample;
                w_left_reg   <= w_center_reg;
                w_center_reg <= right_reg;
                w_up_reg     <= up_here_reg;
                if (produce)
                begin
                    clr_pend_reg <= frame_end;
                end
                else
                begin
                    clr_pend_reg <= clr_pend_reg | frame_end;
                end
            end
        end
    end

    // product stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            a_valid_reg <= produce;
        end
        else if (b_load)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    // product stage payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            p_center_reg  <= PROD_BITS'(c_center_reg * w_center_reg);
            p_up_reg      <= PROD_BITS'(c_up_reg * w_up_reg);
            p_down_reg    <= PROD_BITS'(c_down_reg * w_down_reg);
            p_left_reg    <= PROD_BITS'(c_left_reg * w_left_reg);
            p_right_reg   <= PROD_BITS'(c_right_reg * right_reg);
            a_last_reg    <= frame_end;
            a_restart_reg <= clr_pend_reg;
        end
    end

    // sum of products, saturated to the result range
    always_comb
    begin
        sum = SUM_BITS'(p_center_reg) + SUM_BITS'(p_up_reg) + SUM_BITS'(p_down_reg)
            + SUM_BITS'(p_left_reg) + SUM_BITS'(p_right_reg);
        if (sum > SAT_MAX)
        begin
            sat_value = OUT_BITS'(SAT_MAX);
        end
        else if (sum < SAT_MIN)
        begin
            sat_value = OUT_BITS'(SAT_MIN);
        end
        else
        begin
            sat_value = OUT_BITS'(sum);
        end
        sum_base = a_restart_reg ? '0 : checksum_reg;
    end

    // output register; checksum_reg also holds the running sum of the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            checksum_reg  <= '0;
        end
        else if (b_load)
        begin
            out_valid_reg <= a_valid_reg;
            if (a_valid_reg)
            begin
                checksum_reg <= sum_base + SUM_OUT_BITS'(sat_value);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load && a_valid_reg)
        begin
            value_reg <= sat_value;
            last_reg  <= a_last_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign stencil_value    = value_reg;
    assign running_checksum = checksum_reg;
    assign last             = last_reg;

endmodule
